// ===== src/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 16;
    localparam int HEAP_BYTES   = 65536;

    // Cap on the break so that every payload address fits in 16 bits
    localparam int LIMIT_CAP    = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
    localparam int LIMIT_RESET  = 65536;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [1:0] {
        FN_ALLOC  = 2'd0,
        FN_FREE   = 2'd1,
        FN_RESIZE = 2'd2,
        FN_NOP    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_HEAP    = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_NULL       = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_FIT,
        S_FREE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] size;
        logic        free;
    } entry_t;

endpackage

// ===== src/ffba_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/first_fit_block_allocator.sv =====
// First-fit heap block allocator: block table in RAM, sequential scan engine.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------
//  request   | in_valid / in_stall    | func, request_size, block_address
//  result    | out_valid / out_stall  | result_address, status
//  config    | cfg_we                 | cfg_wdata (heap_limit)
//
// One item at a time. Address lookup and first-fit search each walk the table
// through the RAM read port, one entry per cycle; a resize that must move its
// block walks it twice, first to find the old block and then to fit the new one.
// Reset clears entry count and break and sets the limit to LIMIT_RESET; the table needs no clear.
// A finished result waits in the output register; a new item is taken meanwhile.
module first_fit_block_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] request_size,
    input  logic [15:0] block_address,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] result_address,
    output logic [2:0]  status
);

    localparam int IW = ffba_pkg::IDX_W;
    localparam int CW = ffba_pkg::CNT_W;

    ffba_pkg::state_t  state_reg, state_next;
    ffba_pkg::status_t st_reg, st_next;
    ffba_pkg::status_t out_status_reg, out_status_next;
    ffba_pkg::entry_t  ram_wdata, ram_rdata;

    logic [1:0]    func_reg, func_next;
    logic [15:0]   size_reg, size_next;
    logic [15:0]   addr_reg, addr_next;
    logic          resize_free_reg, resize_free_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic [IW-1:0] old_idx_reg, old_idx_next;
    logic [15:0]   old_start_reg, old_start_next;
    logic [15:0]   old_size_reg, old_size_next;
    logic [15:0]   res_reg, res_next;
    logic [CW-1:0] count_reg, count_next;
    logic [16:0]   break_reg, break_next;
    logic [16:0]   limit_reg, limit_next;
    logic          out_valid_reg, out_valid_next;
    logic [15:0]   out_addr_reg, out_addr_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_raddr;

    logic          accept;
    logic          alloc_like;
    logic          find_hit;
    logic          fit_hit;
    logic          scan_miss;
    logic          can_issue;
    logic          table_full;
    logic          is_top;
    logic [16:0]   limit_eff;
    logic [17:0]   end_sum;

    ffba_ram #(
        .WIDTH($bits(ffba_pkg::entry_t)),
        .DEPTH(ffba_pkg::MAX_BLOCKS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_stall       = (state_reg != ffba_pkg::S_IDLE);
    assign accept         = in_valid && !in_stall;
    assign out_valid      = out_valid_reg;
    assign result_address = out_addr_reg;
    assign status         = out_status_reg;

    assign limit_eff  = (limit_reg > 17'(ffba_pkg::LIMIT_CAP)) ?
                        17'(ffba_pkg::LIMIT_CAP) : limit_reg;
    assign end_sum    = {1'b0, break_reg} + 18'(ffba_pkg::HEADER_BYTES) + {2'b00, size_reg};
    assign table_full = (count_reg >= CW'(ffba_pkg::MAX_BLOCKS));
    assign is_top     = ({1'b0, old_idx_reg} + CW'(1)) == count_reg;

    assign find_hit  = pend_reg &&
                       (({1'b0, ram_rdata.start} + 17'(ffba_pkg::HEADER_BYTES)) ==
                        {1'b0, addr_reg});
    assign fit_hit   = pend_reg && ram_rdata.free && (ram_rdata.size >= size_reg);
    assign scan_miss = !pend_reg && (scan_idx_reg >= count_reg);
    assign can_issue = (scan_idx_reg < count_reg);
    assign ram_raddr = scan_idx_reg[IW-1:0];

    assign alloc_like = (func == ffba_pkg::FN_ALLOC) ||
                        ((func == ffba_pkg::FN_RESIZE) &&
                         ((block_address == 16'd0) || (request_size == 16'd0)));

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        size_next        = size_reg;
        addr_next        = addr_reg;
        resize_free_next = resize_free_reg;
        scan_idx_next    = scan_idx_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        old_idx_next     = old_idx_reg;
        old_start_next   = old_start_reg;
        old_size_next    = old_size_reg;
        res_next         = res_reg;
        st_next          = st_reg;
        count_next       = count_reg;
        break_next       = break_reg;
        limit_next       = cfg_we ? cfg_wdata : limit_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_addr_next    = out_addr_reg;
        out_status_next  = out_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = pend_idx_reg;
        ram_wdata        = ram_rdata;

        case (state_reg)
            ffba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    func_next        = func;
                    size_next        = request_size;
                    addr_next        = block_address;
                    res_next         = 16'd0;
                    st_next          = ffba_pkg::ST_OK;
                    resize_free_next = 1'b0;
                    scan_idx_next    = '0;
                    pend_next        = 1'b0;
                    if ((func == ffba_pkg::FN_NOP) ||
                        ((func == ffba_pkg::FN_FREE) && (block_address == 16'd0)))
                    begin
                        state_next = ffba_pkg::S_OUT;
                    end
                    else if (alloc_like)
                    begin
                        if (request_size == 16'd0)
                        begin
                            st_next    = ffba_pkg::ST_NULL;
                            state_next = ffba_pkg::S_OUT;
                        end
                        else
                        begin
                            state_next = ffba_pkg::S_FIT;
                        end
                    end
                    else
                    begin
                        state_next = ffba_pkg::S_FIND;
                    end
                end
            end

            ffba_pkg::S_FIND:
            begin
                pend_next = 1'b0;
                if (find_hit)
                begin
                    old_idx_next   = pend_idx_reg;
                    old_start_next = ram_rdata.start;
                    old_size_next  = ram_rdata.size;
                    if (func_reg == ffba_pkg::FN_FREE)
                    begin
                        state_next = ffba_pkg::S_FREE;
                    end
                    else if (ram_rdata.size >= size_reg)
                    begin
                        // block already large enough: keep it as it is
                        res_next   = addr_reg;
                        state_next = ffba_pkg::S_OUT;
                    end
                    else
                    begin
                        resize_free_next = 1'b1;
                        scan_idx_next    = '0;
                        state_next       = ffba_pkg::S_FIT;
                    end
                end
                else if (scan_miss)
                begin
                    st_next    = ffba_pkg::ST_UNKNOWN;
                    state_next = ffba_pkg::S_OUT;
                end
                else if (can_issue)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[IW-1:0];
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
            end

            ffba_pkg::S_FIT:
            begin
                pend_next = 1'b0;
                if (fit_hit)
                begin
                    // reuse whole block: clear its free mark
                    ram_we         = 1'b1;
                    ram_waddr      = pend_idx_reg;
                    ram_wdata      = ram_rdata;
                    ram_wdata.free = 1'b0;
                    res_next       = ram_rdata.start + 16'(ffba_pkg::HEADER_BYTES);
                    state_next     = resize_free_reg ? ffba_pkg::S_FREE : ffba_pkg::S_OUT;
                end
                else if (scan_miss)
                begin
                    if (table_full)
                    begin
                        st_next    = ffba_pkg::ST_TABLE_FULL;
                        state_next = ffba_pkg::S_OUT;
                    end
                    else if (end_sum > {1'b0, limit_eff})
                    begin
                        st_next    = ffba_pkg::ST_NO_HEAP;
                        state_next = ffba_pkg::S_OUT;
                    end
                    else
                    begin
                        // append a new block at the break
                        ram_we          = 1'b1;
                        ram_waddr       = count_reg[IW-1:0];
                        ram_wdata.start = break_reg[15:0];
                        ram_wdata.size  = size_reg;
                        ram_wdata.free  = 1'b0;
                        count_next      = count_reg + CW'(1);
                        break_next      = end_sum[16:0];
                        res_next        = break_reg[15:0] + 16'(ffba_pkg::HEADER_BYTES);
                        state_next      = resize_free_reg ? ffba_pkg::S_FREE :
                                                            ffba_pkg::S_OUT;
                    end
                end
                else if (can_issue)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[IW-1:0];
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
            end

            ffba_pkg::S_FREE:
            begin
                if (is_top)
                begin
                    // pop the topmost block and lower the break
                    count_next = count_reg - CW'(1);
                    break_next = break_reg -
                                 (17'(ffba_pkg::HEADER_BYTES) + {1'b0, old_size_reg});
                end
                else
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = old_idx_reg;
                    ram_wdata.start = old_start_reg;
                    ram_wdata.size  = old_size_reg;
                    ram_wdata.free  = 1'b1;
                end
                state_next = ffba_pkg::S_OUT;
            end

            ffba_pkg::S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_reg;
                    out_status_next = st_reg;
                    state_next      = ffba_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffba_pkg::S_IDLE;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            break_reg     <= '0;
            limit_reg     <= 17'(ffba_pkg::LIMIT_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            break_reg     <= break_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        size_reg        <= size_next;
        addr_reg        <= addr_next;
        resize_free_reg <= resize_free_next;
        pend_idx_reg    <= pend_idx_next;
        old_idx_reg     <= old_idx_next;
        old_start_reg   <= old_start_next;
        old_size_reg    <= old_size_next;
        res_reg         <= res_next;
        st_reg          <= st_next;
        out_addr_reg    <= out_addr_next;
        out_status_reg  <= out_status_next;
    end

endmodule

// ===== src/ffba_checker.sv =====
// Port-level checks for the first-fit block allocator, bound to the top level.
module ffba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] result_address,
    input logic [2:0]  status
);

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("new item taken while previous one in work");

    // any failure returns null
    a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ffba_pkg::ST_OK) |-> result_address == 16'd0)
        else $error("failed item returned a non-null address");

    // a payload address always lies past its header
    a_addr_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_address != 16'd0) |->
            result_address >= 16'(ffba_pkg::HEADER_BYTES))
        else $error("payload address inside first header");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
